@@ hw/rtl/trsd_pkg.sv @@
package trsd_pkg;

  // Element header layout
  localparam logic [7:0] LAST_BIT = 8'h80;
  localparam logic [6:0] LEN_MASK = 7'h7F;

  // Field widths
  localparam int unsigned ROW_W = 16;
  localparam int unsigned COL_W = 9;
  localparam int unsigned RUN_W = 7;
  localparam int unsigned DIM_W = 16;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 16'd64;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 16'd64;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OOB       = 2'd1;
  localparam logic [1:0] ST_EARLY_END = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_COLUMN,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } item_t;

  typedef struct packed {
    logic             pixel_valid;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column_index;
    logic [7:0]       pixel_value;
    logic             row_done;
    logic             image_done;
    logic [1:0]       status;
  } result_t;

endpackage

@@ hw/rtl/trsd_if.sv @@
interface trsd_byte_if import trsd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, data_byte, end_of_data, input ready);
  modport sink (input valid, data_byte, end_of_data, output ready);
endinterface

interface trsd_pix_if import trsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             pixel_valid;
  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] column_index;
  logic [7:0]       pixel_value;
  logic             row_done;
  logic             image_done;
  logic [1:0]       status;

  modport source (output valid, pixel_valid, row_index, column_index, pixel_value,
                  row_done, image_done, status, input ready);
  modport sink (input valid, pixel_valid, row_index, column_index, pixel_value,
                row_done, image_done, status, output ready);
endinterface

@@ hw/rtl/transparent_rle_sprite_decoder.sv @@
// Channel   Modport   Handshake        Payload
// bytes     sink      valid / ready    data_byte[7:0], end_of_data
// pixels    source    valid / ready    pixel_valid, row_index[15:0], column_index[8:0],
//                                      pixel_value[7:0], row_done, image_done, status[1:0]
// apb       slave     psel / penable   paddr[2:0], pwdata[31:0], prdata[31:0], pready
//
// One byte per cycle sustained while pixels.ready holds; each byte passes the input register,
// then the result register behind the parse logic.
// rst is synchronous, active high; clears parse state and sets both size registers to 64.
// A stalled result register holds; the input register keeps taking bytes while it can
// drain into the result register in the same cycle.
module transparent_rle_sprite_decoder import trsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  trsd_byte_if.sink             bytes,
  trsd_pix_if.source            pixels,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [DIM_W-1:0] image_width, image_height;
  logic             s_valid;
  item_t            s_item;
  logic             o_valid;
  result_t          o_result;
  result_t          dec_result;
  logic             s_adv;

  trsd_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .image_width  (image_width),
    .image_height (image_height)
  );

  // Pipeline flow control
  assign s_adv       = s_valid && (!o_valid || pixels.ready);
  assign bytes.ready = !s_valid || s_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (bytes.ready) begin
      s_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s_item.data_byte   <= bytes.data_byte;
      s_item.end_of_data <= bytes.end_of_data;
    end
  end

  trsd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .step         (s_adv),
    .item         (s_item),
    .image_width  (image_width),
    .image_height (image_height),
    .result       (dec_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= s_adv || (o_valid && !pixels.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv) o_result <= dec_result;
  end

  assign pixels.valid        = o_valid;
  assign pixels.pixel_valid  = o_result.pixel_valid;
  assign pixels.row_index    = o_result.row_index;
  assign pixels.column_index = o_result.column_index;
  assign pixels.pixel_value  = o_result.pixel_value;
  assign pixels.row_done     = o_result.row_done;
  assign pixels.image_done   = o_result.image_done;
  assign pixels.status       = o_result.status;

`ifndef SYNTHESIS
  // a pixel write never comes from an out-of-bounds element
  a_pix_ok: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_result.pixel_valid) |-> (o_result.status != ST_OOB))
    else $error("pixel write with bounds error status");

  // non-pixel results carry zero column and value
  a_nopix_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_result.pixel_valid) |->
      ((o_result.column_index == '0) && (o_result.pixel_value == '0)))
    else $error("stray column or value without pixel");

  // a held byte stays in the input register until it moves on
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !s_adv) |=> s_valid)
    else $error("input register dropped a byte");
`endif

endmodule

@@ hw/rtl/trsd_cfg.sv @@
module trsd_cfg import trsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [DIM_W-1:0]      image_width,
  output logic [DIM_W-1:0]      image_height
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes, one per access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Readback
  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = {{(APB_DATA_W-DIM_W){1'b0}}, image_width};
      REG_IMAGE_HEIGHT: prdata = {{(APB_DATA_W-DIM_W){1'b0}}, image_height};
      default:          prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/trsd_decode.sv @@
module trsd_decode import trsd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  item_t            item,
  input  logic [DIM_W-1:0] image_width,
  input  logic [DIM_W-1:0] image_height,
  output result_t          result
);

  phase_t           phase, phase_next;
  logic [ROW_W-1:0] row, row_next;
  logic [COL_W-1:0] col, col_next;
  logic [RUN_W-1:0] run, run_next;
  logic             last, last_next;
  logic [1:0]       err, err_next;

  logic             active, hdr, colph, pix;
  logic [COL_W-1:0] span;
  logic             oob, elem_end, rdone, img_end;
  logic [ROW_W-1:0] row_inc;

  // Phase decode and element end conditions
  assign active   = (err == ST_OK) && (phase != PH_DONE);
  assign hdr      = active && (phase == PH_HEADER);
  assign colph    = active && (phase == PH_COLUMN);
  assign pix      = active && (phase == PH_PIXELS);
  assign span     = {1'b0, item.data_byte} + {2'b00, run};
  assign oob      = colph && ({{(DIM_W-COL_W){1'b0}}, span} > image_width);
  assign elem_end = (colph && !oob && (run == '0)) || (pix && (run == RUN_W'(1)));
  assign rdone    = elem_end && last;
  assign row_inc  = row + ROW_W'(1);
  assign img_end  = rdone && (row_inc == image_height);

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HEADER: if (hdr) phase_next = PH_COLUMN;
      PH_COLUMN: begin
        if (colph && !oob) begin
          if (elem_end) phase_next = img_end ? PH_DONE : PH_HEADER;
          else phase_next = PH_PIXELS;
        end
      end
      PH_PIXELS: if (elem_end) phase_next = img_end ? PH_DONE : PH_HEADER;
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_HEADER;
    endcase
  end

  // Datapath state updates
  always_comb begin
    row_next  = row;
    col_next  = col;
    run_next  = run;
    last_next = last;
    err_next  = err;
    if (hdr) begin
      last_next = |(item.data_byte & LAST_BIT);
      run_next  = item.data_byte[RUN_W-1:0] & LEN_MASK;
    end
    if (colph) col_next = {1'b0, item.data_byte};
    if (pix) begin
      col_next = col + COL_W'(1);
      run_next = run - RUN_W'(1);
    end
    if (rdone && !img_end) row_next = row_inc;
    // bounds error wins over premature end
    if (oob) err_next = ST_OOB;
    else if (active && item.end_of_data && (phase_next != PH_DONE)) err_next = ST_EARLY_END;
  end

  // Result for the byte in flight
  always_comb begin
    result.pixel_valid  = pix;
    result.row_index    = row;
    result.column_index = pix ? col : '0;
    result.pixel_value  = pix ? item.data_byte : '0;
    result.row_done     = rdone;
    result.image_done   = (phase_next == PH_DONE);
    result.status       = err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      row   <= '0;
      col   <= '0;
      run   <= '0;
      last  <= 1'b0;
      err   <= ST_OK;
    end else if (step) begin
      phase <= phase_next;
      row   <= row_next;
      col   <= col_next;
      run   <= run_next;
      last  <= last_next;
      err   <= err_next;
    end
  end

`ifndef SYNTHESIS
  // errors are sticky until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != ST_OK) |=> (err == $past(err)))
    else $error("error status changed after being set");

  // finished image never returns to parsing
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |=> (phase == PH_DONE))
    else $error("left done phase");

  // a pixel is only written inside the configured width
  a_pix_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (step && pix) |-> ({{(DIM_W-COL_W){1'b0}}, col} < image_width))
    else $error("pixel column beyond image width");
`endif

endmodule
